// ===== hw/rtl/wwm_pkg.sv =====
// ----------------------------------------------------------------------------
// Weekday and week-of-month package
// Shared constants, pipeline control type and small calendar helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package wwm_pkg;

   // Field widths of the date and result beats.
   localparam int DateW  = 27;
   localparam int YearW  = 14;   // raw decoded year, up to 13421
   localparam int RemW   = 14;   // remainder after the year digits
   localparam int TwoDigW = 7;   // a two-digit decimal value
   localparam int WdW    = 3;
   localparam int WeekW  = 3;
   localparam int WYearW = 12;
   localparam int MonthW = 4;
   localparam int DayW   = 5;

   // Number of register stages from input capture to the result register.
   localparam int NumStages = 6;

   // Accepted year window and the base year of the day count.
   localparam logic [YearW-1:0] BaseYear = 14'd2015;
   localparam logic [YearW-1:0] LastYear = 14'd2099;

   // Reciprocal multipliers for the constant divisions.
   localparam logic [27:0] DivTenKMul    = 28'd219902326;  // 2^41 / 10000, rounded up
   localparam logic [14:0] DivHundredMul = 15'd20972;      // 2^21 / 100, rounded up
   localparam logic [7:0]  DivSevenMul   = 8'd147;         // 2^10 / 7, rounded up

   // Per-stage load strobes from the pipeline control.
   typedef struct packed {
      logic [NumStages-1:0] load;
   } pipe_ctl_type;

   // Year digits of a packed decimal date.
   function automatic logic [YearW-1:0] div10000(input logic [DateW-1:0] x);
      logic [54:0] p;
      p = 55'(x) * 55'(DivTenKMul);
      return p[54:41];
   endfunction

   // Upper two digits of a four-digit value.
   function automatic logic [TwoDigW-1:0] div100(input logic [RemW-1:0] x);
      logic [28:0] p;
      p = 29'(x) * 29'(DivHundredMul);
      return p[27:21];
   endfunction

   // Quotient by seven of a value below 204.
   function automatic logic [5:0] div7(input logic [7:0] x);
      logic [15:0] p;
      p = 16'(x) * 16'(DivSevenMul);
      return p[15:10];
   endfunction

   // Remainder by seven of a value below 204.
   function automatic logic [2:0] mod7(input logic [7:0] x);
      logic [5:0] q;
      logic [8:0] r;
      q = div7(x);
      r = 9'(x) - 9'(q) * 9'd7;
      return r[2:0];
   endfunction

   // Days before the first of the month, reduced modulo seven.
   function automatic logic [2:0] cum_mod7(input logic [MonthW-1:0] m, input logic leap);
      logic [2:0] c;
      unique case (m)
         4'd1:    c = 3'd0;
         4'd2:    c = 3'd3;
         4'd3:    c = leap ? 3'd4 : 3'd3;
         4'd4:    c = leap ? 3'd0 : 3'd6;
         4'd5:    c = leap ? 3'd2 : 3'd1;
         4'd6:    c = leap ? 3'd5 : 3'd4;
         4'd7:    c = leap ? 3'd0 : 3'd6;
         4'd8:    c = leap ? 3'd3 : 3'd2;
         4'd9:    c = leap ? 3'd6 : 3'd5;
         4'd10:   c = leap ? 3'd1 : 3'd0;
         4'd11:   c = leap ? 3'd4 : 3'd3;
         4'd12:   c = leap ? 3'd6 : 3'd5;
         default: c = 3'd0;
      endcase
      return c;
   endfunction

   // Length of a month in days.
   function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
      logic [DayW-1:0] n;
      unique case (m)
         4'd2:    n = leap ? 5'd29 : 5'd28;
         4'd4,
         4'd6,
         4'd9,
         4'd11:   n = 5'd30;
         default: n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wwm_digit_split.sv =====
// ----------------------------------------------------------------------------
// Decimal digit split
// Splits a packed YYYYMMDD date into year, month digits and the remainder
// over three register stages, with a reciprocal multiply in the first and third.
// ----------------------------------------------------------------------------
`default_nettype none

module wwm_digit_split (
   input  wire logic                          clock,
   input  wire wwm_pkg::pipe_ctl_type         ctl,
   input  wire logic [wwm_pkg::DateW-1:0]     date,
   output logic      [wwm_pkg::YearW-1:0]     year,
   output logic      [wwm_pkg::TwoDigW-1:0]   month,
   output logic      [wwm_pkg::RemW-1:0]      rem
);
   import wwm_pkg::*;

   logic [DateW-1:0]   date1_ff;
   logic [YearW-1:0]   year1_ff, year1_in;
   logic [YearW-1:0]   year2_ff;
   logic [RemW-1:0]    rem2_ff, rem2_in;
   logic [YearW-1:0]   year3_ff;
   logic [RemW-1:0]    rem3_ff;
   logic [TwoDigW-1:0] month3_ff, month3_in;
   logic [DateW-1:0]   yprod;

   // Stage one: year digits by reciprocal multiply.
   assign year1_in = div10000(date);

   // Stage two: strip the year digits.
   assign yprod   = DateW'(year1_ff) * DateW'(14'd10000);
   assign rem2_in = RemW'(date1_ff - yprod);

   // Stage three: month digits of the remainder.
   assign month3_in = div100(rem2_ff);

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         date1_ff <= date;
         year1_ff <= year1_in;
      end
      if (ctl.load[2]) begin
         year2_ff <= year1_ff;
         rem2_ff  <= rem2_in;
      end
      if (ctl.load[3]) begin
         year3_ff  <= year2_ff;
         rem3_ff   <= rem2_ff;
         month3_ff <= month3_in;
      end
   end

   assign year  = year3_ff;
   assign month = month3_ff;
   assign rem   = rem3_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/wwm_calendar.sv =====
// ----------------------------------------------------------------------------
// Calendar stage
// Checks the decoded date, finds its weekday and then the week of the month
// counted by the week's Sunday, with rollback into the previous month.
// ----------------------------------------------------------------------------
`default_nettype none

module wwm_calendar (
   input  wire logic                         clock,
   input  wire wwm_pkg::pipe_ctl_type        ctl,
   input  wire logic [wwm_pkg::YearW-1:0]    year,
   input  wire logic [wwm_pkg::TwoDigW-1:0]  month,
   input  wire logic [wwm_pkg::RemW-1:0]     rem,
   output logic      [wwm_pkg::WdW-1:0]      weekday,
   output logic      [wwm_pkg::WeekW-1:0]    week_number,
   output logic      [wwm_pkg::WYearW-1:0]   week_year,
   output logic      [wwm_pkg::MonthW-1:0]   week_month,
   output logic                              range_error
);
   import wwm_pkg::*;

   // Stage four signals.
   logic [RemW-1:0]    day_full;
   logic [TwoDigW-1:0] day_dec;
   logic               err4_in, leap4_in;
   logic [YearW-1:0]   dy_full;
   logic [6:0]         dy;
   logic [4:0]         leaps;
   logic [7:0]         wsum;
   logic [WdW-1:0]     wd4_in;

   logic               err4_ff, leap4_ff;
   logic [WdW-1:0]     wd4_ff;
   logic [DayW-1:0]    day4_ff;
   logic [MonthW-1:0]  month4_ff;
   logic [WYearW-1:0]  year4_ff;

   // Output stage signals.
   logic [MonthW-1:0]  pm;
   logic [DayW-1:0]    last;
   logic [2:0]         lwd;
   logic [DayW-1:0]    sunday;
   logic [WdW-1:0]     wd_in;
   logic [WeekW-1:0]   week_in;
   logic [WYearW-1:0]  wyear_in;
   logic [MonthW-1:0]  wmonth_in;

   logic [WdW-1:0]     wd_ff;
   logic [WeekW-1:0]   week_ff;
   logic [WYearW-1:0]  wyear_ff;
   logic [MonthW-1:0]  wmonth_ff;
   logic               err_ff;

   // Day digits and range checks.
   assign day_full = rem - RemW'(month) * RemW'(7'd100);
   assign day_dec  = day_full[TwoDigW-1:0];
   assign err4_in  = (year < BaseYear) || (year > LastYear) ||
                     (month == 7'd0) || (month > 7'd12) ||
                     (day_dec == 7'd0) || (day_dec > 7'd31);
   assign leap4_in = (year[1:0] == 2'd0);

   // Weekday: 365 is one modulo seven, so each year moves the weekday by one.
   assign dy_full = year - BaseYear;
   assign dy      = dy_full[6:0];
   assign leaps   = 5'((8'(dy) + 8'd2) >> 2);
   assign wsum    = 8'(cum_mod7(month[MonthW-1:0], leap4_in)) + 8'(dy) + 8'(leaps)
                    + 8'(day_dec) + 8'd3;
   assign wd4_in  = mod7(wsum);

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         err4_ff   <= err4_in;
         leap4_ff  <= leap4_in;
         wd4_ff    <= wd4_in;
         day4_ff   <= day_dec[DayW-1:0];
         month4_ff <= month[MonthW-1:0];
         year4_ff  <= year[WYearW-1:0];
      end
   end

   // Week of the month, rolling back when the Sunday lies in the prior month.
   assign pm   = (month4_ff == 4'd1) ? 4'd12 : month4_ff - 4'd1;
   assign last = month_len(pm, leap4_ff);
   assign lwd  = mod7(8'(wd4_ff) + 8'd35 - 8'(day4_ff));

   always_comb begin
      wd_in     = '0;
      week_in   = '0;
      wyear_in  = '0;
      wmonth_in = '0;
      sunday    = day4_ff - DayW'(wd4_ff);
      if (!err4_ff) begin
         wd_in     = wd4_ff;
         wyear_in  = year4_ff;
         wmonth_in = month4_ff;
         if (day4_ff <= DayW'(wd4_ff)) begin
            sunday    = last - DayW'(lwd);
            wmonth_in = pm;
            if (month4_ff == 4'd1) begin
               wyear_in = year4_ff - 12'd1;
            end
         end
         week_in = WeekW'(div7(8'(sunday) + 8'd6));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         wd_ff     <= wd_in;
         week_ff   <= week_in;
         wyear_ff  <= wyear_in;
         wmonth_ff <= wmonth_in;
         err_ff    <= err4_ff;
      end
   end

   assign weekday     = wd_ff;
   assign week_number = week_ff;
   assign week_year   = wyear_ff;
   assign week_month  = wmonth_ff;
   assign range_error = err_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/weekday_and_week_of_month.sv =====
// ----------------------------------------------------------------------------
// Weekday and week of month
// Decodes a packed decimal date YYYYMMDD into its weekday and the week of the
// month that the week's Sunday falls in.
//
// Use:
//   The request channel (req_valid, req_stall, req_packed_date) carries one
//   date per beat. The response channel (rsp_valid, rsp_stall and the rsp_
//   result fields) returns exactly one result beat per date, in order.
//   A beat moves at a rising edge where valid is high and stall is low.
//   A date accepted at one edge reaches the response port through six
//   register stages (capture, year digits, remainder, month digits,
//   weekday, week count). Every stage holds its own valid bit.
//   Throughput is one date per cycle while the receiver does not stall.
//   When the receiver stalls, the response beat holds and stages behind it
//   keep filling bubbles; req_stall rises only when every stage is full.
//   Dates with a year outside 2015 to 2099, or a bad month or day field,
//   give range_error set and all other result fields zero.
//   Reset empties the pipeline; no stored data needs clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module weekday_and_week_of_month (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [wwm_pkg::DateW-1:0]    req_packed_date,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [wwm_pkg::WdW-1:0]      rsp_weekday,
   output logic      [wwm_pkg::WeekW-1:0]    rsp_week_number,
   output logic      [wwm_pkg::WYearW-1:0]   rsp_week_year,
   output logic      [wwm_pkg::MonthW-1:0]   rsp_week_month,
   output logic                              rsp_range_error
);
   import wwm_pkg::*;

   logic [NumStages-1:0] valid_ff, valid_in;
   logic [NumStages-1:0] adv;
   pipe_ctl_type         ctl;
   logic [DateW-1:0]     date0_ff;
   logic [YearW-1:0]     year;
   logic [TwoDigW-1:0]   month;
   logic [RemW-1:0]      rem;

   // A stage may take a new beat when it is empty or its contents move on.
   always_comb begin
      adv[NumStages-1] = !valid_ff[NumStages-1] || !rsp_stall;
      for (int i = NumStages - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   // Load strobes and next valid bits per stage.
   always_comb begin
      for (int i = 0; i < NumStages; i++) begin
         if (i == 0) begin
            ctl.load[i] = adv[i] && req_valid;
            valid_in[i] = adv[i] ? req_valid : valid_ff[i];
         end else begin
            ctl.load[i] = adv[i] && valid_ff[i-1];
            valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Input capture register.
   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         date0_ff <= req_packed_date;
      end
   end

   wwm_digit_split u_split (
      .clock (clock),
      .ctl   (ctl),
      .date  (date0_ff),
      .year  (year),
      .month (month),
      .rem   (rem)
   );

   wwm_calendar u_calendar (
      .clock       (clock),
      .ctl         (ctl),
      .year        (year),
      .month       (month),
      .rem         (rem),
      .weekday     (rsp_weekday),
      .week_number (rsp_week_number),
      .week_year   (rsp_week_year),
      .week_month  (rsp_week_month),
      .range_error (rsp_range_error)
   );

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[NumStages-1];

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Weekday and week-of-month testbench
// Feeds packed decimal dates through the request channel and checks every
// response beat against a calendar predictor kept in the bench. A short table
// of hand-picked dates runs first, then a long random mix of well-formed and
// malformed dates, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wwm_pkg::*;

   // One response beat, field for field.
   typedef struct packed {
      logic [WdW-1:0]    weekday;
      logic [WeekW-1:0]  week_number;
      logic [WYearW-1:0] week_year;
      logic [MonthW-1:0] week_month;
      logic              range_error;
   } week_result_type;

   // One row of the directed table; typed rows carry their answer.
   typedef struct packed {
      logic [DateW-1:0] date_code;
      logic             typed;
      week_result_type  answer;
   } date_row_type;

   localparam int unsigned BaseWeekday = 4;   // 2015-01-01 is a Thursday
   localparam int unsigned NumRandom   = 1850;
   localparam int unsigned HoldCycles  = 80;
   localparam int unsigned DrainCycles = 20;
   localparam int unsigned HoldAfter   = 400;
   localparam int unsigned CalmFirst   = 1000;
   localparam int unsigned CalmLast    = 1200;

   localparam week_result_type RangeErr = '{'0, '0, '0, '0, 1'b1};
   localparam week_result_type Untyped  = '0;

   localparam int unsigned DaysBefore [12] =
      '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
   localparam int unsigned MonthDays [12] =
      '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   localparam int NumDirected = 26;
   localparam date_row_type DirectedRows [NumDirected] = '{
      // January rollback into December of the year before the base year.
      '{27'd20150101, 1'b1, '{3'd4, 3'd4, 12'd2014, 4'd12, 1'b0}},
      // First Sunday of the base year opens week one.
      '{27'd20150104, 1'b1, '{3'd0, 3'd1, 12'd2015, 4'd1, 1'b0}},
      // Year, month and day fields out of range.
      '{27'd0,        1'b1, RangeErr},
      '{27'd20141231, 1'b1, RangeErr},
      '{27'd21000101, 1'b1, RangeErr},
      '{27'd99991231, 1'b1, RangeErr},
      '{27'h7FFFFFF,  1'b1, RangeErr},
      '{27'h4000000,  1'b1, RangeErr},
      '{27'd20150001, 1'b1, RangeErr},
      '{27'd20151301, 1'b1, RangeErr},
      '{27'd20159901, 1'b1, RangeErr},
      '{27'd20150100, 1'b1, RangeErr},
      '{27'd20150132, 1'b1, RangeErr},
      '{27'd20150199, 1'b1, RangeErr},
      // Ordinary dates, year ends, leap days and days past the month end.
      '{27'd20150102, 1'b0, Untyped},
      '{27'd20150131, 1'b0, Untyped},
      '{27'd20150230, 1'b0, Untyped},
      '{27'd20150331, 1'b0, Untyped},
      '{27'd20150401, 1'b0, Untyped},
      '{27'd20151231, 1'b0, Untyped},
      '{27'd20160229, 1'b0, Untyped},
      '{27'd20160301, 1'b0, Untyped},
      '{27'd20200101, 1'b0, Untyped},
      '{27'd20990101, 1'b0, Untyped},
      '{27'd20990228, 1'b0, Untyped},
      '{27'd20991231, 1'b0, Untyped}
   };

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [DateW-1:0]   req_packed_date;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [WdW-1:0]     rsp_weekday;
   logic [WeekW-1:0]   rsp_week_number;
   logic [WYearW-1:0]  rsp_week_year;
   logic [MonthW-1:0]  rsp_week_month;
   logic               rsp_range_error;

   week_result_type offered_q [$];   // answers for dates offered, not yet taken
   week_result_type awaited_q [$];   // answers for dates taken, result pending
   int unsigned     results_seen = 0;
   int unsigned     error_count  = 0;

   weekday_and_week_of_month DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_packed_date (req_packed_date),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_weekday     (rsp_weekday),
      .rsp_week_number (rsp_week_number),
      .rsp_week_year   (rsp_week_year),
      .rsp_week_month  (rsp_week_month),
      .rsp_range_error (rsp_range_error)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Calendar predictor: weekday and the week whose Sunday holds the date.
   function automatic week_result_type predict_week(input logic [DateW-1:0] date_code);
      int unsigned     year, month, day, years_on, wd, sunday, prev_month, prev_len;
      bit              leap;
      week_result_type r;
      year  = date_code / 10000;
      month = (date_code % 10000) / 100;
      day   = date_code % 100;
      r     = '0;
      if (year < BaseYear || year > LastYear || month < 1 || month > 12 ||
          day < 1 || day > 31) begin
         r.range_error = 1'b1;
         return r;
      end
      leap     = (year % 4 == 0);
      years_on = year - BaseYear;
      wd = (DaysBefore[month-1] + ((leap && month > 2) ? 1 : 0) + 365 * years_on +
            (years_on + 2) / 4 + day - 1 + BaseWeekday) % 7;
      r.week_year  = WYearW'(year);
      r.week_month = MonthW'(month);
      if (day < 1 + wd) begin
         // The Sunday of this week lies in the month before.
         prev_month   = (month == 1) ? 12 : month - 1;
         prev_len     = MonthDays[prev_month-1] + ((prev_month == 2 && leap) ? 1 : 0);
         sunday       = prev_len - (wd + 35 - day) % 7;
         r.week_month = MonthW'(prev_month);
         if (month == 1) begin
            r.week_year = WYearW'(year - 1);
         end
      end else begin
         sunday = day - wd;
      end
      r.weekday     = WdW'(wd);
      r.week_number = WeekW'((sunday + 6) / 7);
      return r;
   endfunction

   // Idle length: mostly none, some short, a few long.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) begin
         return 0;
      end else if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Offer one date beat; called at a falling edge, returns at one.
   task automatic offer_date(input logic [DateW-1:0] date_code,
                             input week_result_type answer, input bit no_gap);
      int unsigned gap;
      gap = no_gap ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      offered_q.push_back(answer);
      req_valid       <= 1'b1;
      req_packed_date <= date_code;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
   endtask

   // Compare one result field and report a mismatch.
   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Watch both channels at the rising edge.
   always @(posedge clock) begin : watch_beats
      week_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            awaited_q.push_back(offered_q.pop_front());
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (awaited_q.size() == 0) begin
               $display("%0t: result beat with none expected, actual %h", $time,
                        {rsp_weekday, rsp_week_number, rsp_week_year, rsp_week_month,
                         rsp_range_error});
               error_count++;
            end else begin
               want = awaited_q.pop_front();
               check_field("weekday", want.weekday, rsp_weekday);
               check_field("week_number", want.week_number, rsp_week_number);
               check_field("week_year", want.week_year, rsp_week_year);
               check_field("week_month", want.week_month, rsp_week_month);
               check_field("range_error", want.range_error, rsp_range_error);
            end
         end
      end
   end

   // Response side: random stalls, one long hold, and a calm stretch.
   initial begin : drive_rsp_stall
      int unsigned stall_len;
      bit          held;
      held      = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && results_seen >= HoldAfter) begin
            // Long hold so the pipeline fills and the input stalls.
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         if (results_seen < CalmFirst || results_seen >= CalmLast) begin
            stall_len = pick_gap();
            if (stall_len != 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(negedge clock);
            end
         end
      end
   end

   // Request side: directed table, then random dates, then drain.
   initial begin : drive_requests
      logic [DateW-1:0] date_code;
      int unsigned      roll, year, month, day;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_packed_date = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DirectedRows[i]) begin
         offer_date(DirectedRows[i].date_code,
                    DirectedRows[i].typed ? DirectedRows[i].answer
                                          : predict_week(DirectedRows[i].date_code),
                    1'b0);
      end

      for (int unsigned n = 0; n < NumRandom; n++) begin
         roll  = $urandom_range(99);
         year  = ($urandom_range(19) == 0) ? ($urandom_range(1) ? 2015 : 2099)
                                           : $urandom_range(2015, 2099);
         month = $urandom_range(1, 12);
         day   = $urandom_range(1, 31);
         if (roll >= 75 && roll < 83) begin
            month = $urandom_range(1) ? 0 : $urandom_range(13, 99);
         end else if (roll >= 83 && roll < 90) begin
            day = $urandom_range(1) ? 0 : $urandom_range(32, 99);
         end else if (roll >= 90 && roll < 94) begin
            year = $urandom_range(1) ? $urandom_range(0, 2014) : $urandom_range(2100, 9999);
         end
         date_code = DateW'(year * 10000 + month * 100 + day);
         if (roll >= 94) begin
            // Raw noise over the whole field width.
            date_code = DateW'($urandom());
         end
         offer_date(date_code, predict_week(date_code),
                    n >= CalmFirst && n < CalmLast);
      end
      req_valid <= 1'b0;

      while (awaited_q.size() != 0 || offered_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin : watchdog
      #10_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
